### sv/hsv_adj_pkg.sv
// hsv_adj_pkg: shared constants for the hsv hue / saturation / value adjust block
// no dependencies; imported by every module of the block

package hsv_adj_pkg;

  // default fraction width of the unsigned q1.f saturation and value datapath
  localparam int unsigned FRAC_BITS_DEF = 16;

  // pixel channel width and packed stream width
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned PIX_W  = 3 * CHAN_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_SHIFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_GAIN  = 2'd2;

  // hue in degrees, 0..359
  localparam int unsigned HUE_W = 9;

  // reciprocal table scale: recip(x) = floor(2^RECIP_SHIFT / x)
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

endpackage

### sv/hsv_adj_rgb2hsv.sv
// hsv_adj_rgb2hsv: three-stage rgb to hsv conversion (hue, saturation, value)
// depends on hsv_adj_pkg; divisions use a reciprocal table and one correction step

module hsv_adj_rgb2hsv import hsv_adj_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [CHAN_W-1:0]   red_i,
  input  logic [CHAN_W-1:0]   green_i,
  input  logic [CHAN_W-1:0]   blue_i,
  output logic                valid_o,
  output logic [HUE_W-1:0]    hue_o,
  output logic [FRAC_BITS:0]  sat_o,
  output logic [FRAC_BITS:0]  val_o
);

  localparam int unsigned SW    = FRAC_BITS + 1;
  localparam int unsigned NUM_W = 17;
  localparam int unsigned PH_W  = NUM_W + RECIP_W;
  localparam int unsigned PS_W  = CHAN_W + RECIP_W;
  localparam int unsigned RS_W  = FRAC_BITS + CHAN_W + 1;
  localparam int unsigned HD_W  = NUM_W + CHAN_W;
  localparam longint unsigned RECIP_255 = (64'd1 << RECIP_SHIFT) / 255;

  // reciprocal table, entry zero is never used
  logic [RECIP_W-1:0] recip_tab [256];
  for (genvar gi = 0; gi < 256; gi++) begin : g_recip
    localparam longint unsigned Den = (gi == 0) ? 1 : gi;
    localparam longint unsigned Rcp = (64'd1 << RECIP_SHIFT) / Den;
    assign recip_tab[gi] = RECIP_W'(Rcp);
  end

  // stage 1: max, min, range and hue numerator
  logic [CHAN_W-1:0] mx, mn, rng;
  logic signed [18:0] sr, sg, sb, sd, num;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    rng = mx - mn;
    sr  = signed'({11'b0, red_i});
    sg  = signed'({11'b0, green_i});
    sb  = signed'({11'b0, blue_i});
    sd  = signed'({11'b0, rng});
    if (rng == '0) begin
      num = '0;
    end else if (mx == red_i) begin
      if (green_i >= blue_i) num = 19'sd60 * (sg - sb);
      else num = 19'sd360 * sd - 19'sd60 * (sb - sg);
    end else if (mx == green_i) begin
      num = 19'sd120 * sd + 19'sd60 * (sb - sr);
    end else begin
      num = 19'sd240 * sd + 19'sd60 * (sr - sg);
    end
  end

  logic              s1_valid_q;
  logic [CHAN_W-1:0] s1_mx_q, s1_rng_q;
  logic [NUM_W-1:0]  s1_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else if (en_i) s1_valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_mx_q  <= mx;
      s1_rng_q <= rng;
      s1_num_q <= num[NUM_W-1:0];
    end
  end

  // stage 2: estimate quotients by reciprocal multiply
  logic [PH_W-1:0] prod_h;
  logic [PS_W-1:0] prod_s, prod_v;

  always_comb begin
    prod_h = PH_W'(s1_num_q) * PH_W'(recip_tab[s1_rng_q]);
    prod_s = PS_W'(s1_rng_q) * PS_W'(recip_tab[s1_mx_q]);
    prod_v = PS_W'(s1_mx_q) * PS_W'(RECIP_255);
  end

  logic              s2_valid_q;
  logic [CHAN_W-1:0] s2_mx_q, s2_rng_q;
  logic [NUM_W-1:0]  s2_num_q, s2_qh_q;
  logic [SW-1:0]     s2_qs_q, s2_qv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_valid_q <= 1'b0;
    else if (en_i) s2_valid_q <= s1_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_mx_q  <= s1_mx_q;
      s2_rng_q <= s1_rng_q;
      s2_num_q <= s1_num_q;
      s2_qh_q  <= prod_h[RECIP_SHIFT +: NUM_W];
      s2_qs_q  <= prod_s[RECIP_SHIFT-FRAC_BITS +: SW];
      s2_qv_q  <= prod_v[RECIP_SHIFT-FRAC_BITS +: SW];
    end
  end

  // stage 3: remainder check, the estimate is at most one low
  logic [HD_W-1:0]  rem_h;
  logic [RS_W-1:0]  rem_s, rem_v;
  logic [NUM_W-1:0] hue_full;
  logic [SW-1:0]    sat_d, val_d;

  always_comb begin
    rem_h = HD_W'(s2_num_q) - HD_W'(s2_qh_q) * HD_W'(s2_rng_q);
    rem_s = RS_W'({s2_rng_q, {FRAC_BITS{1'b0}}}) - RS_W'(s2_qs_q) * RS_W'(s2_mx_q);
    rem_v = RS_W'({s2_mx_q, {FRAC_BITS{1'b0}}}) - RS_W'(s2_qv_q) * RS_W'(8'd255);
    hue_full = s2_qh_q + NUM_W'(rem_h >= HD_W'(s2_rng_q));
    sat_d = s2_qs_q + SW'(rem_s >= RS_W'(s2_mx_q));
    val_d = s2_qv_q + SW'(rem_v >= RS_W'(8'd255));
    if (s2_rng_q == '0) hue_full = '0;
    if (s2_mx_q == '0) sat_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (en_i) valid_o <= s2_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_o <= hue_full[HUE_W-1:0];
      sat_o <= sat_d;
      val_o <= val_d;
    end
  end

endmodule

### sv/hsv_adj_gain.sv
// hsv_adj_gain: three-stage hue shift, saturation and value gain with clamping
// depends on hsv_adj_pkg; also splits the hue into sector and sector fraction

module hsv_adj_gain import hsv_adj_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [HUE_W-1:0]             hue_i,
  input  logic [FRAC_BITS:0]           sat_i,
  input  logic [FRAC_BITS:0]           val_i,
  input  logic [CFG_DATA_W-1:0]        hue_shift_i,
  input  logic signed [CFG_DATA_W-1:0] sat_gain_i,
  input  logic signed [CFG_DATA_W-1:0] val_gain_i,
  output logic                         valid_o,
  output logic [2:0]                   sector_o,
  output logic [FRAC_BITS:0]           frac_o,
  output logic [FRAC_BITS:0]           sat_o,
  output logic [FRAC_BITS:0]           val_o
);

  localparam int unsigned SW   = FRAC_BITS + 1;
  localparam int unsigned P_W  = FRAC_BITS + 10;
  localparam int unsigned M_W  = FRAC_BITS + 4;
  localparam int unsigned Q_W  = FRAC_BITS + 2;
  localparam int unsigned MP_W = P_W + M_W;
  localparam longint unsigned RECIP_100 = (64'd1 << P_W) / 100;
  localparam logic [SW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // sector fraction table: floor(i * one / 60)
  logic [SW-1:0] frac_tab [64];
  for (genvar gi = 0; gi < 64; gi++) begin : g_frac
    localparam longint unsigned Fv = (gi < 60) ? ((longint'(gi) << FRAC_BITS) / 60) : 0;
    assign frac_tab[gi] = SW'(Fv);
  end

  // gain factor 100 + gain, forced to zero when not positive
  function automatic logic [8:0] gain_factor(input logic signed [CFG_DATA_W-1:0] g);
    logic signed [9:0] k;
    k = 10'sd100 + 10'(g);
    return (k > 10'sd0) ? k[8:0] : 9'd0;
  endfunction

  // stage 4: hue shift mod 360, gain products
  logic [9:0]     hue_sum;
  logic [HUE_W-1:0] hue_mod;

  always_comb begin
    hue_sum = 10'(hue_i) + 10'(hue_shift_i);
    priority if (hue_sum >= 10'd720) hue_mod = HUE_W'(hue_sum - 10'd720);
    else if (hue_sum >= 10'd360) hue_mod = HUE_W'(hue_sum - 10'd360);
    else hue_mod = HUE_W'(hue_sum);
  end

  logic             s4_valid_q;
  logic [HUE_W-1:0] s4_hue_q;
  logic [P_W-1:0]   s4_ps_q, s4_pv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_valid_q <= 1'b0;
    else if (en_i) s4_valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_hue_q <= hue_mod;
      s4_ps_q  <= P_W'(sat_i) * P_W'(gain_factor(sat_gain_i));
      s4_pv_q  <= P_W'(val_i) * P_W'(gain_factor(val_gain_i));
    end
  end

  // stage 5: sector split, divide by 100 estimate
  logic [2:0]       sector;
  logic [HUE_W-1:0] base;
  logic [5:0]       hue_rem;
  logic [MP_W-1:0]  mp_s, mp_v;

  always_comb begin
    priority if (s4_hue_q >= 9'd300) begin
      sector = 3'd5; base = 9'd300;
    end else if (s4_hue_q >= 9'd240) begin
      sector = 3'd4; base = 9'd240;
    end else if (s4_hue_q >= 9'd180) begin
      sector = 3'd3; base = 9'd180;
    end else if (s4_hue_q >= 9'd120) begin
      sector = 3'd2; base = 9'd120;
    end else if (s4_hue_q >= 9'd60) begin
      sector = 3'd1; base = 9'd60;
    end else begin
      sector = 3'd0; base = 9'd0;
    end
    hue_rem = 6'(s4_hue_q - base);
    mp_s = MP_W'(s4_ps_q) * MP_W'(RECIP_100);
    mp_v = MP_W'(s4_pv_q) * MP_W'(RECIP_100);
  end

  logic           s5_valid_q;
  logic [2:0]     s5_sector_q;
  logic [SW-1:0]  s5_frac_q;
  logic [P_W-1:0] s5_ps_q, s5_pv_q;
  logic [Q_W-1:0] s5_qs_q, s5_qv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_valid_q <= 1'b0;
    else if (en_i) s5_valid_q <= s4_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_sector_q <= sector;
      s5_frac_q   <= frac_tab[hue_rem];
      s5_ps_q     <= s4_ps_q;
      s5_pv_q     <= s4_pv_q;
      s5_qs_q     <= mp_s[P_W +: Q_W];
      s5_qv_q     <= mp_v[P_W +: Q_W];
    end
  end

  // stage 6: correct the quotient and clamp to one
  function automatic logic [SW-1:0] fix_clamp(input logic [P_W-1:0] p,
                                               input logic [Q_W-1:0] q0);
    logic [P_W-1:0] r;
    logic [Q_W-1:0] q;
    r = p - P_W'(q0) * P_W'(7'd100);
    q = q0 + Q_W'(r >= P_W'(7'd100));
    return (q > Q_W'(ONE)) ? ONE : q[SW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (en_i) valid_o <= s5_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sector_o <= s5_sector_q;
      frac_o   <= s5_frac_q;
      sat_o    <= fix_clamp(s5_ps_q, s5_qs_q);
      val_o    <= fix_clamp(s5_pv_q, s5_qv_q);
    end
  end

`ifndef SYNTHESIS
  a_hue_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q |-> s4_hue_q < 9'd360)
    else $error("shifted hue not below 360");
  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> sat_o <= ONE)
    else $error("saturation above one");
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (frac_o < ONE && sector_o <= 3'd5))
    else $error("sector or fraction out of range");
`endif

endmodule

### sv/hsv_adj_hsv2rgb.sv
// hsv_adj_hsv2rgb: three-stage six-sector hsv to rgb conversion
// depends on hsv_adj_pkg; last stage is the output register

module hsv_adj_hsv2rgb import hsv_adj_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [2:0]         sector_i,
  input  logic [FRAC_BITS:0] frac_i,
  input  logic [FRAC_BITS:0] sat_i,
  input  logic [FRAC_BITS:0] val_i,
  output logic               valid_o,
  output logic [CHAN_W-1:0]  red_o,
  output logic [CHAN_W-1:0]  green_o,
  output logic [CHAN_W-1:0]  blue_o
);

  localparam int unsigned SW  = FRAC_BITS + 1;
  localparam int unsigned PW  = 2 * SW;
  localparam int unsigned BW  = SW + CHAN_W;
  localparam logic [SW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // q1.f product, truncated back to q1.f
  function automatic logic [SW-1:0] qmul(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [PW-1:0] p;
    p = PW'(a) * PW'(b);
    return p[FRAC_BITS +: SW];
  endfunction

  // q1.f to byte: (x * 255) >> f
  function automatic logic [CHAN_W-1:0] to_byte(input logic [SW-1:0] x);
    logic [BW-1:0] p;
    p = BW'(x) * BW'(8'd255);
    return p[FRAC_BITS +: CHAN_W];
  endfunction

  // stage 7: f*s, (1-f)*s, p
  logic          s7_valid_q;
  logic [2:0]    s7_sector_q;
  logic [SW-1:0] s7_fs_q, s7_gs_q, s7_p_q, s7_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s7_valid_q <= 1'b0;
    else if (en_i) s7_valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s7_sector_q <= sector_i;
      s7_fs_q     <= qmul(frac_i, sat_i);
      s7_gs_q     <= qmul(ONE - frac_i, sat_i);
      s7_p_q      <= qmul(val_i, ONE - sat_i);
      s7_v_q      <= val_i;
    end
  end

  // stage 8: q and t
  logic          s8_valid_q;
  logic [2:0]    s8_sector_q;
  logic [SW-1:0] s8_p_q, s8_q_q, s8_t_q, s8_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s8_valid_q <= 1'b0;
    else if (en_i) s8_valid_q <= s7_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s8_sector_q <= s7_sector_q;
      s8_p_q      <= s7_p_q;
      s8_q_q      <= qmul(s7_v_q, ONE - s7_fs_q);
      s8_t_q      <= qmul(s7_v_q, ONE - s7_gs_q);
      s8_v_q      <= s7_v_q;
    end
  end

  // stage 9: sector select and byte conversion
  logic [SW-1:0] ro, go, bo;

  always_comb begin
    unique case (s8_sector_q)
      3'd0: begin ro = s8_v_q; go = s8_t_q; bo = s8_p_q; end
      3'd1: begin ro = s8_q_q; go = s8_v_q; bo = s8_p_q; end
      3'd2: begin ro = s8_p_q; go = s8_v_q; bo = s8_t_q; end
      3'd3: begin ro = s8_p_q; go = s8_q_q; bo = s8_v_q; end
      3'd4: begin ro = s8_t_q; go = s8_p_q; bo = s8_v_q; end
      default: begin ro = s8_v_q; go = s8_p_q; bo = s8_q_q; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (en_i) valid_o <= s8_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_o   <= to_byte(ro);
      green_o <= to_byte(go);
      blue_o  <= to_byte(bo);
    end
  end

endmodule

### sv/hsv_hue_sat_value_adjust.sv
// hsv_hue_sat_value_adjust: one pixel per clock, each accepted input transaction yielding its
// output transaction; the nine register stages (three for rgb to hsv, three for hue shift
// and gains, three for hsv to rgb) all advance together, stalling only
// while the output register holds an unaccepted pixel. The gain stages read the
// configuration registers, so pixels still in the first three stages at a write pick up
// the new values; write them only while no pixel is in flight. Depends on hsv_adj_pkg and
// the three stage modules.

module hsv_hue_sat_value_adjust import hsv_adj_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,  // in_blue, in_green, in_red
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [PIX_W-1:0]      m_axis_tdata,  // out_blue, out_green, out_red
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  logic [CFG_DATA_W-1:0]        hue_shift_q;
  logic signed [CFG_DATA_W-1:0] sat_gain_q, val_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_shift_q <= '0;
      sat_gain_q  <= '0;
      val_gain_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HUE_SHIFT: hue_shift_q <= cfg_data_i;
        CFG_SAT_GAIN:  sat_gain_q  <= signed'(cfg_data_i);
        CFG_VAL_GAIN:  val_gain_q  <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the output register is free or being drained
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic               v_hsv, v_adj;
  logic [HUE_W-1:0]   hue;
  logic [FRAC_BITS:0] sat, val, sat_adj, val_adj, frac;
  logic [2:0]         sector;

  hsv_adj_rgb2hsv #(.FRAC_BITS(FRAC_BITS)) u_rgb2hsv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .red_i   (s_axis_tdata[2*CHAN_W +: CHAN_W]),
    .green_i (s_axis_tdata[CHAN_W +: CHAN_W]),
    .blue_i  (s_axis_tdata[0 +: CHAN_W]),
    .valid_o (v_hsv),
    .hue_o   (hue),
    .sat_o   (sat),
    .val_o   (val)
  );

  hsv_adj_gain #(.FRAC_BITS(FRAC_BITS)) u_gain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (v_hsv),
    .hue_i       (hue),
    .sat_i       (sat),
    .val_i       (val),
    .hue_shift_i (hue_shift_q),
    .sat_gain_i  (sat_gain_q),
    .val_gain_i  (val_gain_q),
    .valid_o     (v_adj),
    .sector_o    (sector),
    .frac_o      (frac),
    .sat_o       (sat_adj),
    .val_o       (val_adj)
  );

  hsv_adj_hsv2rgb #(.FRAC_BITS(FRAC_BITS)) u_hsv2rgb (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v_adj),
    .sector_i (sector),
    .frac_i   (frac),
    .sat_i    (sat_adj),
    .val_i    (val_adj),
    .valid_o  (m_axis_tvalid),
    .red_o    (m_axis_tdata[2*CHAN_W +: CHAN_W]),
    .green_o  (m_axis_tdata[CHAN_W +: CHAN_W]),
    .blue_o   (m_axis_tdata[0 +: CHAN_W])
  );

endmodule

### test/hsv_adj_checker.sv
// hsv_adj_checker: watches both pixel streams, predicts each adjusted pixel and compares
// depends on hsv_adj_pkg; the configuration is mirrored from the write port

`timescale 1ns / 1ps

module hsv_adj_checker import hsv_adj_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [PIX_W-1:0]      m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o,
  output int                    pending_o
);

  localparam longint unsigned ONE = 64'd1 << FRAC_BITS;

  logic [8:0] hue_shift_q;
  int         sat_gain_q;
  int         val_gain_q;
  int         err_cnt = 0;
  logic [PIX_W-1:0] pixel_fifo[$];

  assign pending_o = pixel_fifo.size();
  assign errors_o  = err_cnt;

  // scale by (100+gain)/100, clamp to one
  function automatic longint unsigned scale_gain(longint unsigned x, int gain);
    int k;
    longint unsigned r;
    k = 100 + gain;
    if (k <= 0) return 0;
    r = (x * longint'(k)) / 100;
    return (r > ONE) ? ONE : r;
  endfunction

  function automatic logic [7:0] frac_to_chan(longint unsigned x);
    longint unsigned y;
    y = (x * 255) >> FRAC_BITS;
    return y[7:0];
  endfunction

  // full rgb -> hsv -> adjust -> rgb prediction
  function automatic logic [PIX_W-1:0] adjust_pixel(logic [PIX_W-1:0] pix);
    int b, g, r, mx, mn, d, h, sector;
    longint unsigned s, v, f, fs, gs, p, q, t, ro, go, bo;
    b = pix[7:0];
    g = pix[15:8];
    r = pix[23:16];
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (d == 0) h = 0;
    else if (mx == r) h = (g >= b) ? (60 * (g - b)) / d : (360 * d - 60 * (b - g)) / d;
    else if (mx == g) h = (120 * d + 60 * (b - r)) / d;
    else h = (240 * d + 60 * (r - g)) / d;
    v = (longint'(mx) * ONE) / 255;
    s = (mx == 0) ? 0 : (longint'(d) * ONE) / longint'(mx);
    h = (h + int'(hue_shift_q)) % 360;
    s = scale_gain(s, sat_gain_q);
    v = scale_gain(v, val_gain_q);
    sector = h / 60;
    f = (longint'(h % 60) * ONE) / 60;
    fs = (f * s) >> FRAC_BITS;
    gs = ((ONE - f) * s) >> FRAC_BITS;
    p = (v * (ONE - s)) >> FRAC_BITS;
    q = (v * (ONE - fs)) >> FRAC_BITS;
    t = (v * (ONE - gs)) >> FRAC_BITS;
    case (sector)
      0: begin ro = v; go = t; bo = p; end
      1: begin ro = q; go = v; bo = p; end
      2: begin ro = p; go = v; bo = t; end
      3: begin ro = p; go = q; bo = v; end
      4: begin ro = t; go = p; bo = v; end
      default: begin ro = v; go = p; bo = q; end
    endcase
    return {frac_to_chan(ro), frac_to_chan(go), frac_to_chan(bo)};
  endfunction

  task automatic report_mismatch(string what, logic [PIX_W-1:0] got, logic [PIX_W-1:0] exp);
    $display("mismatch %s at %0t: got %h expected %h", what, $realtime, got, exp);
    err_cnt++;
  endtask

  // mirror configuration, predict on input, compare on output
  always @(posedge clk_i or negedge rst_ni) begin
    logic [PIX_W-1:0] exp_pix;
    if (!rst_ni) begin
      hue_shift_q <= '0;
      sat_gain_q  <= 0;
      val_gain_q  <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) pixel_fifo.push_back(adjust_pixel(s_axis_tdata));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HUE_SHIFT: hue_shift_q <= cfg_data_i;
          CFG_SAT_GAIN:  sat_gain_q  <= int'($signed(cfg_data_i));
          CFG_VAL_GAIN:  val_gain_q  <= int'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_fifo.size() == 0) begin
          report_mismatch("unexpected pixel", m_axis_tdata, '0);
        end else begin
          exp_pix = pixel_fifo.pop_front();
          if (m_axis_tdata[7:0] !== exp_pix[7:0])
            report_mismatch("blue", m_axis_tdata, exp_pix);
          if (m_axis_tdata[15:8] !== exp_pix[15:8])
            report_mismatch("green", m_axis_tdata, exp_pix);
          if (m_axis_tdata[23:16] !== exp_pix[23:16])
            report_mismatch("red", m_axis_tdata, exp_pix);
        end
      end
    end
  end

endmodule

### test/tb_hsv_hue_sat_value_adjust.sv
// tb_hsv_hue_sat_value_adjust: stimulus, random idling and verdict for the hsv adjust block
// depends on hsv_adj_pkg, the block and hsv_adj_checker

`timescale 1ns / 1ps

module tb_hsv_hue_sat_value_adjust;
  import hsv_adj_pkg::*;

  localparam int LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [PIX_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [PIX_W-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  int errors;
  int pending;
  int cycles = 0;
  bit long_hold = 1'b0;
  bit hold_done = 1'b0;

  hsv_hue_sat_value_adjust uut (.*);

  hsv_adj_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("hsv_hue_sat_value_adjust verification failed");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_done = 1'b1;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(posedge clk_i);
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] pix, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // let the checker record the last transaction before waiting on its count
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [8:0] hs, logic [8:0] sg, logic [8:0] vg);
    write_reg(CFG_HUE_SHIFT, hs);
    write_reg(CFG_SAT_GAIN, sg);
    write_reg(CFG_VAL_GAIN, vg);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int rand_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  // stimulus
  initial begin
    logic [PIX_W-1:0] dir[$];
    logic [8:0] hs, sg, vg;
    dir = '{24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff, 24'h808080,
            24'hff00ff, 24'hff8040, 24'hff4080, 24'h40ff80, 24'h8040ff, 24'hffff00,
            24'h00ffff, 24'h010000, 24'h000001, 24'hfe01fe, 24'h7f7f80, 24'haa55aa};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: reset config, then extremes incl. shift beyond 359 and gains beyond range
    foreach (dir[i]) send_pixel(dir[i], 0);
    drain();
    set_config(9'd511, 9'h100, 9'd255);
    foreach (dir[i]) send_pixel(dir[i], rand_gap());
    drain();
    // random phases with varied settings, extremes first
    for (int ph = 0; ph < 13; ph++) begin
      case (ph)
        0: begin hs = 9'd359; sg = 9'(-100); vg = 9'd200; end
        1: begin hs = 9'd0;   sg = 9'd200;   vg = 9'(-100); end
        2: begin hs = 9'd1;   sg = 9'(-101); vg = 9'd201; end
        default: begin
          hs = 9'($urandom_range(0, 511));
          sg = 9'($urandom);
          vg = ($urandom_range(0, 1)) ? 9'($urandom_range(0, 300) - 100) : 9'($urandom);
        end
      endcase
      set_config(hs, sg, vg);
      if (ph == 4) long_hold = 1'b1;
      for (int n = 0; n < 150; n++)
        send_pixel(24'($urandom), (ph == 4) ? 0 : rand_gap());
      drain();
    end
    repeat (12) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("hsv_hue_sat_value_adjust verification clean");
    end else begin
      $display("hsv_hue_sat_value_adjust verification failed");
    end
    $finish;
  end

endmodule
